>>> rtl/bdph_pkg.sv
// Shared types and constants for the button debounce and gesture block.
`timescale 1ns / 1ps
`default_nettype none
package bdph_pkg;

  localparam int NUM_BUTTONS_DEF = 8;
  localparam int RAW_W     = 8;    // raw button bits carried by an item
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int EPOCH_W   = 16;
  localparam int OUT_IDX_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_MS_RST     = 16'd600;

  localparam logic KIND_POLL  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  localparam logic GESTURE_PRESS = 1'b0;
  localparam logic GESTURE_HOLD  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_END
  } state_t;

  typedef struct packed {
    logic load;    // capture the input item, clear pending results
    logic scan;    // process the button selected by the scan index
    logic commit;  // hand pending results to the output stage
  } ctrl_cmd_t;

endpackage
`default_nettype wire

>>> rtl/button_debounce_press_hold.sv
// Top level of the button debouncer with press and hold gestures.
//
// Usage:
//  - Input channel (in_*): one item per poll. in_kind = poll tick or reset until
//    release, in_buttons_down = raw levels, in_now_ms = wrapping ms time,
//    in_control_epoch = tag latched when a press turns stable.
//  - Output channel (out_*): one item per gesture, in ascending button order;
//    out_last marks the final gesture of a poll. Polls without gestures give none.
//  - Config channel (cfg_*): index 0 debounce_ms, index 1 hold_ms; always ready.
//    Write only while the block is idle.
//  - Flow: an item is accepted, then each button passes in turn through the
//    shared scan step, then a wrap-up step; a new item is taken only after the
//    wrap-up of the previous one. Gestures sit in an output buffer that drains
//    one button slot per cycle, unless the receiver stalls, while the next item
//    is scanned; the wrap-up waits only if that buffer still holds results of
//    the previous item and the new item has results of its own.
//  - Reset (rst_n low, synchronous): all button state clears, thresholds go to
//    20 ms and 600 ms, pending gestures are dropped. No clearing pass is needed.
//  - Receiver stall: out_valid holds with stable payload until out_ready.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_press_hold #(
  parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // config writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bdph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bdph_pkg::CFG_W-1:0]       cfg_data,
  // poll items
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_kind,
  input  wire logic [bdph_pkg::RAW_W-1:0]       in_buttons_down,
  input  wire logic [bdph_pkg::TIME_W-1:0]      in_now_ms,
  input  wire logic [bdph_pkg::EPOCH_W-1:0]     in_control_epoch,
  // gesture items
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [bdph_pkg::OUT_IDX_W-1:0]        out_button_index,
  output logic                                  out_gesture_kind,
  output logic [bdph_pkg::EPOCH_W-1:0]          out_press_epoch_out,
  output logic                                  out_last
);
  import bdph_pkg::*;

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  ctrl_cmd_t              cmd;
  logic [IDX_W-1:0]       scan_idx;
  logic                   pend_any, emit_any;
  logic [NUM_BUTTONS-1:0] pend_vld, pend_kind;
  logic [EPOCH_W-1:0]     pend_epoch [NUM_BUTTONS];

  // config registers accept a write every cycle
  assign cfg_ready = 1'b1;

  bdph_ctrl #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pend_any (pend_any),
    .emit_any (emit_any),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  bdph_dp #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_kind          (in_kind),
    .in_buttons_down  (in_buttons_down),
    .in_now_ms        (in_now_ms),
    .in_control_epoch (in_control_epoch),
    .cmd              (cmd),
    .scan_idx         (scan_idx),
    .pend_any         (pend_any),
    .pend_vld         (pend_vld),
    .pend_kind        (pend_kind),
    .pend_epoch       (pend_epoch)
  );

  bdph_emit #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IDX_W       (IDX_W)
  ) u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .commit              (cmd.commit),
    .pend_vld            (pend_vld),
    .pend_kind           (pend_kind),
    .pend_epoch          (pend_epoch),
    .emit_any            (emit_any),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_button_index    (out_button_index),
    .out_gesture_kind    (out_gesture_kind),
    .out_press_epoch_out (out_press_epoch_out),
    .out_last            (out_last)
  );

endmodule
`default_nettype wire

>>> rtl/bdph_ctrl.sv
// Sequencer: accepts items, walks the buttons, hands results to the output stage.
`timescale 1ns / 1ps
`default_nettype none
module bdph_ctrl #(
  parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF,
  parameter int IDX_W       = 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              pend_any,
  input  wire logic              emit_any,
  output bdph_pkg::ctrl_cmd_t    cmd,
  output logic [IDX_W-1:0]       scan_idx
);
  import bdph_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_END: begin
        // wait while the output stage still holds results of the previous item and this item has results too
        if (!(pend_any && emit_any)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: cmd.scan = 1'b1;
      ST_END:  cmd.commit = pend_any && !emit_any;
      default: ;
    endcase
  end

  assign scan_idx = idx_r;

endmodule
`default_nettype wire

>>> rtl/bdph_dp.sv
// Datapath: config registers, per-button debounce state and the scan step.
`timescale 1ns / 1ps
`default_nettype none
module bdph_dp #(
  parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF,
  parameter int IDX_W       = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [bdph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdph_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_kind,
  input  wire logic [bdph_pkg::RAW_W-1:0]    in_buttons_down,
  input  wire logic [bdph_pkg::TIME_W-1:0]   in_now_ms,
  input  wire logic [bdph_pkg::EPOCH_W-1:0]  in_control_epoch,
  input  wire bdph_pkg::ctrl_cmd_t           cmd,
  input  wire logic [IDX_W-1:0]              scan_idx,
  output logic                               pend_any,
  output logic [NUM_BUTTONS-1:0]             pend_vld,
  output logic [NUM_BUTTONS-1:0]             pend_kind,
  output logic [bdph_pkg::EPOCH_W-1:0]       pend_epoch [NUM_BUTTONS]
);
  import bdph_pkg::*;

  logic [CFG_W-1:0]   debounce_r, hold_ms_r;

  logic               kind_r;
  logic [RAW_W-1:0]   bits_r;
  logic [TIME_W-1:0]  now_r;
  logic [EPOCH_W-1:0] cepoch_r;

  logic [NUM_BUTTONS-1:0] supp_r, cand_r, stable_r, held_r;
  logic [TIME_W-1:0]      cand_since_r [NUM_BUTTONS];
  logic [TIME_W-1:0]      down_since_r [NUM_BUTTONS];
  logic [EPOCH_W-1:0]     epoch_r      [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] pend_vld_r, pend_kind_r;
  logic [EPOCH_W-1:0]     pend_epoch_r [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] raw_vec;

  // buttons beyond the raw input width read as up
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_raw
    if (g < RAW_W) begin : g_bit
      assign raw_vec[g] = bits_r[g];
    end else begin : g_up
      assign raw_vec[g] = 1'b0;
    end
  end

  // scan step for the selected button
  logic              raw, supp_cur, cand_cur, stable_cur, held_cur;
  logic [TIME_W-1:0] cand_age, down_age;
  logic              supp_nxt, cand_nxt, stable_nxt, held_nxt;
  logic              cand_since_we, down_we, fire, fire_kind;

  always_comb begin
    raw        = raw_vec[scan_idx];
    supp_cur   = supp_r[scan_idx];
    cand_cur   = cand_r[scan_idx];
    stable_cur = stable_r[scan_idx];
    held_cur   = held_r[scan_idx];
    cand_age   = now_r - cand_since_r[scan_idx];
    down_age   = now_r - down_since_r[scan_idx];

    supp_nxt      = supp_cur;
    cand_nxt      = cand_cur;
    stable_nxt    = stable_cur;
    held_nxt      = held_cur;
    cand_since_we = 1'b0;
    down_we       = 1'b0;
    fire          = 1'b0;
    fire_kind     = GESTURE_PRESS;

    if (kind_r == KIND_RESET) begin
      supp_nxt   = supp_cur | raw;
      stable_nxt = 1'b0;
      cand_nxt   = raw;
      held_nxt   = 1'b0;
    end else if (supp_cur) begin
      if (!raw) supp_nxt = 1'b0;
    end else if (raw != cand_cur) begin
      cand_nxt      = raw;
      cand_since_we = 1'b1;
    end else if (cand_age < TIME_W'(debounce_r)) begin
      // level not settled yet
    end else if (raw && !stable_cur) begin
      stable_nxt = 1'b1;
      down_we    = 1'b1;
      held_nxt   = 1'b0;
    end else if (raw && !held_cur) begin
      if (down_age >= TIME_W'(hold_ms_r)) begin
        held_nxt  = 1'b1;
        fire      = 1'b1;
        fire_kind = GESTURE_HOLD;
      end
    end else if (!raw && stable_cur) begin
      stable_nxt = 1'b0;
      if (!held_cur) begin
        fire      = 1'b1;
        fire_kind = GESTURE_PRESS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_MS_RST;
      hold_ms_r  <= HOLD_MS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS: debounce_r <= cfg_data;
        CFG_HOLD_MS:     hold_ms_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      bits_r   <= in_buttons_down;
      now_r    <= in_now_ms;
      cepoch_r <= in_control_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supp_r   <= '0;
      cand_r   <= '0;
      stable_r <= '0;
      held_r   <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cand_since_r[i] <= '0;
        down_since_r[i] <= '0;
        epoch_r[i]      <= '0;
      end
    end else if (cmd.scan) begin
      supp_r[scan_idx]   <= supp_nxt;
      cand_r[scan_idx]   <= cand_nxt;
      stable_r[scan_idx] <= stable_nxt;
      held_r[scan_idx]   <= held_nxt;
      if (cand_since_we) cand_since_r[scan_idx] <= now_r;
      if (down_we) begin
        down_since_r[scan_idx] <= now_r;
        epoch_r[scan_idx]      <= cepoch_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= '0;
    end else if (cmd.load) begin
      pend_vld_r <= '0;
    end else if (cmd.scan) begin
      pend_vld_r[scan_idx] <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pend_kind_r[scan_idx]  <= fire_kind;
      pend_epoch_r[scan_idx] <= epoch_r[scan_idx];
    end
  end

  assign pend_any   = |pend_vld_r;
  assign pend_vld   = pend_vld_r;
  assign pend_kind  = pend_kind_r;
  assign pend_epoch = pend_epoch_r;

endmodule
`default_nettype wire

>>> rtl/bdph_emit.sv
// Output stage: holds one item's gestures and sends them in button order.
`timescale 1ns / 1ps
`default_nettype none
module bdph_emit #(
  parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF,
  parameter int IDX_W       = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            commit,
  input  wire logic [NUM_BUTTONS-1:0]          pend_vld,
  input  wire logic [NUM_BUTTONS-1:0]          pend_kind,
  input  wire logic [bdph_pkg::EPOCH_W-1:0]    pend_epoch [NUM_BUTTONS],
  output logic                                 emit_any,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [bdph_pkg::OUT_IDX_W-1:0]       out_button_index,
  output logic                                 out_gesture_kind,
  output logic [bdph_pkg::EPOCH_W-1:0]         out_press_epoch_out,
  output logic                                 out_last
);
  import bdph_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  logic [NUM_BUTTONS-1:0] vld_r, kind_r;
  logic [EPOCH_W-1:0]     epoch_r [NUM_BUTTONS];
  logic [IDX_W-1:0]       ptr_r;

  logic                   oval_r, okind_r, olast_r;
  logic [OUT_IDX_W-1:0]   oidx_r;
  logic [EPOCH_W-1:0]     oepoch_r;

  logic                   out_free, step, hit;
  logic [NUM_BUTTONS-1:0] above;

  assign emit_any = |vld_r;
  assign out_free = !oval_r || out_ready;
  assign step     = emit_any && out_free;
  assign hit      = vld_r[ptr_r];

  // any result still waiting past the current pointer
  always_comb begin
    for (int j = 0; j < NUM_BUTTONS; j++) begin
      above[j] = vld_r[j] && (IDX_W'(j) > ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ptr_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      if (out_ready) oval_r <= 1'b0;
      if (commit) begin
        vld_r <= pend_vld;
        ptr_r <= '0;
      end else if (step) begin
        ptr_r <= (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
        if (hit) begin
          vld_r[ptr_r] <= 1'b0;
          oval_r       <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      kind_r  <= pend_kind;
      epoch_r <= pend_epoch;
    end
    if (!commit && step && hit) begin
      oidx_r   <= OUT_IDX_W'(ptr_r);
      okind_r  <= kind_r[ptr_r];
      oepoch_r <= epoch_r[ptr_r];
      olast_r  <= ~|above;
    end
  end

  assign out_valid           = oval_r;
  assign out_button_index    = oidx_r;
  assign out_gesture_kind    = okind_r;
  assign out_press_epoch_out = oepoch_r;
  assign out_last            = olast_r;

endmodule
`default_nettype wire

>>> verif/button_debounce_press_hold_tb.sv
// Self-checking testbench for the button debouncer with press and hold gestures.
`timescale 1ns / 1ps
module button_debounce_press_hold_tb;
  import bdph_pkg::*;

  localparam int NB            = NUM_BUTTONS_DEF;
  localparam int SETTLE_CYCLES = 3 * (NB + 3);
  localparam int DRAIN_LIMIT   = 5000;
  // worst item: sender gap, scan, eight results each behind a long stall
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic                 gesture;
    logic [EPOCH_W-1:0]   epoch;
    logic                 last;
  } gesture_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_kind;
  logic [RAW_W-1:0]     in_buttons_down;
  logic [TIME_W-1:0]    in_now_ms;
  logic [EPOCH_W-1:0]   in_control_epoch;
  logic                 out_valid;
  logic                 out_ready;
  logic [OUT_IDX_W-1:0] out_button_index;
  logic                 out_gesture_kind;
  logic [EPOCH_W-1:0]   out_press_epoch_out;
  logic                 out_last;

  button_debounce_press_hold u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_buttons_down     (in_buttons_down),
    .in_now_ms           (in_now_ms),
    .in_control_epoch    (in_control_epoch),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_button_index    (out_button_index),
    .out_gesture_kind    (out_gesture_kind),
    .out_press_epoch_out (out_press_epoch_out),
    .out_last            (out_last)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------
  // Predictor state: a private copy of the per-button debounce state and
  // of the two threshold registers.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0]   cur_debounce_ms;
  logic [CFG_W-1:0]   cur_hold_ms;
  logic               btn_suppressed  [NB];
  logic               btn_cand_down   [NB];
  logic [TIME_W-1:0]  btn_cand_since  [NB];
  logic               btn_stable_down [NB];
  logic [TIME_W-1:0]  btn_down_since  [NB];
  logic [EPOCH_W-1:0] btn_press_epoch [NB];
  logic               btn_hold_fired  [NB];

  gesture_t expected_gestures[$];

  int error_count;
  int items_sent;
  int random_items;
  int gestures_checked;
  int reg_writes;
  int cycle_count;

  task automatic clear_button_model();
    cur_debounce_ms = DEBOUNCE_MS_RST;
    cur_hold_ms     = HOLD_MS_RST;
    for (int b = 0; b < NB; b++) begin
      btn_suppressed[b]  = 1'b0;
      btn_cand_down[b]   = 1'b0;
      btn_cand_since[b]  = '0;
      btn_stable_down[b] = 1'b0;
      btn_down_since[b]  = '0;
      btn_press_epoch[b] = '0;
      btn_hold_fired[b]  = 1'b0;
    end
  endtask

  // Apply one accepted item to the button state and queue its gestures.
  task automatic predict_gestures(input logic kind, input logic [RAW_W-1:0] raw_bits,
                                  input logic [TIME_W-1:0] now,
                                  input logic [EPOCH_W-1:0] epoch);
    gesture_t          found[$];
    gesture_t          g;
    logic              raw;
    logic              fire;
    logic              gkind;
    logic [TIME_W-1:0] elapsed;
    if (kind == KIND_RESET) begin
      // buttons down now stay ignored until released; no gestures
      for (int b = 0; b < NB; b++) begin
        raw = (b < RAW_W) ? raw_bits[b] : 1'b0;
        if (raw) btn_suppressed[b] = 1'b1;
        btn_stable_down[b] = 1'b0;
        btn_cand_down[b]   = raw;
        btn_hold_fired[b]  = 1'b0;
      end
      return;
    end
    for (int b = 0; b < NB; b++) begin
      raw   = (b < RAW_W) ? raw_bits[b] : 1'b0;
      fire  = 1'b0;
      gkind = GESTURE_PRESS;
      if (btn_suppressed[b]) begin
        // the release poll only clears the mark
        if (!raw) btn_suppressed[b] = 1'b0;
      end else if (raw != btn_cand_down[b]) begin
        btn_cand_down[b]  = raw;
        btn_cand_since[b] = now;
      end else begin
        elapsed = now - btn_cand_since[b];
        if (elapsed >= {16'd0, cur_debounce_ms}) begin
          if (raw && !btn_stable_down[b]) begin
            btn_stable_down[b] = 1'b1;
            btn_down_since[b]  = now;
            btn_press_epoch[b] = epoch;
            btn_hold_fired[b]  = 1'b0;
          end else if (raw && !btn_hold_fired[b]) begin
            elapsed = now - btn_down_since[b];
            if (elapsed >= {16'd0, cur_hold_ms}) begin
              btn_hold_fired[b] = 1'b1;
              fire  = 1'b1;
              gkind = GESTURE_HOLD;
            end
          end else if (!raw && btn_stable_down[b]) begin
            btn_stable_down[b] = 1'b0;
            fire = !btn_hold_fired[b];
          end
        end
      end
      if (fire) begin
        g.idx     = b[OUT_IDX_W-1:0];
        g.gesture = gkind;
        g.epoch   = btn_press_epoch[b];
        g.last    = 1'b0;
        found = {found, g};
      end
    end
    for (int k = 0; k < found.size(); k++) begin
      g      = found[k];
      g.last = (k == found.size() - 1);
      expected_gestures = {expected_gestures, g};
    end
  endtask

  // ---------------------------------------------------------------------
  // Input side. send_item is entered at a rising edge and returns at the
  // edge that accepted the item, leaving in_valid high; whoever idles the
  // channel next lowers it. That keeps one NBA per signal per step.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic kind, input logic [RAW_W-1:0] raw_bits,
                           input logic [TIME_W-1:0] now, input logic [EPOCH_W-1:0] epoch);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_buttons_down  <= raw_bits;
    in_now_ms        <= now;
    in_control_epoch <= epoch;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_gestures(kind, raw_bits, now, epoch);
    items_sent++;
  endtask

  task automatic poll(input logic [RAW_W-1:0] raw_bits, input logic [TIME_W-1:0] now,
                      input logic [EPOCH_W-1:0] epoch);
    send_item(KIND_POLL, raw_bits, now, epoch);
  endtask

  task automatic pause_input(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_gestures();
    int waited;
    waited = 0;
    while (expected_gestures.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Idle the block: all gestures out, then room for an item that gives none.
  task automatic settle();
    in_valid <= 1'b0;
    wait_for_gestures();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == CFG_DEBOUNCE_MS) cur_debounce_ms = value;
    else cur_hold_ms = value;
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold);
    settle();
    write_reg(CFG_DEBOUNCE_MS, debounce);
    write_reg(CFG_HOLD_MS, hold);
  endtask

  // ---------------------------------------------------------------------
  // Result side: receiver stalls on its own pattern of stretches.
  // ---------------------------------------------------------------------
  int stall_mode;
  int stall_left;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      // solid stalls are kept short so no result waits too long
      stall_left = (stall_mode == 3) ? $urandom_range(2, 20) : $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= ($urandom_range(0, 4) == 0);
      end
      default: begin
        out_ready <= 1'b0;
      end
    endcase
  end

  // Each accepted gesture is checked against the oldest prediction.
  always @(posedge clk) begin
    gesture_t exp_g;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_gestures.size() == 0) begin
        $display("%0t: unexpected gesture: button %0d kind %0d epoch %0h last %0d",
                 $time, out_button_index, out_gesture_kind, out_press_epoch_out, out_last);
        error_count++;
      end else begin
        exp_g = expected_gestures.pop_front();
        gestures_checked++;
        if (out_button_index !== exp_g.idx) begin
          $display("%0t: button_index expected %0d actual %0d",
                   $time, exp_g.idx, out_button_index);
          error_count++;
        end
        if (out_gesture_kind !== exp_g.gesture) begin
          $display("%0t: gesture_kind expected %0d actual %0d",
                   $time, exp_g.gesture, out_gesture_kind);
          error_count++;
        end
        if (out_press_epoch_out !== exp_g.epoch) begin
          $display("%0t: press_epoch_out expected %0h actual %0h",
                   $time, exp_g.epoch, out_press_epoch_out);
          error_count++;
        end
        if (out_last !== exp_g.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_g.last, out_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d gestures still expected", $time, expected_gestures.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // Reset thresholds: a short press, then all eight buttons held to a hold.
  task automatic test_press_and_hold();
    poll(8'h01, 32'd1000, 16'h0001);
    poll(8'h01, 32'd1020, 16'hFFFF);   // stable, epoch all ones latched
    poll(8'h00, 32'd1030, 16'h1234);
    poll(8'h00, 32'd1050, 16'h1234);   // release -> press gesture
    poll(8'hFF, 32'd2000, 16'h0000);
    poll(8'hFF, 32'd2020, 16'h0000);   // all stable, epoch zero
    poll(8'hFF, 32'd2619, 16'hAAAA);   // one ms short of the hold
    poll(8'hFF, 32'd2620, 16'h5555);   // eight holds in one poll
    poll(8'h00, 32'd2700, 16'h0000);
    poll(8'h00, 32'd2720, 16'h0000);   // release after hold: silent
  endtask

  // Reset item: buttons down at that moment are ignored until released.
  task automatic test_reset_item();
    poll(8'h0F, 32'd3000, 16'h0101);
    poll(8'h0F, 32'd3020, 16'h0202);
    send_item(KIND_RESET, 8'h05, 32'd3030, 16'h0303);
    poll(8'h0F, 32'd3040, 16'h0404);   // 0 and 2 skipped, 1 and 3 restart
    poll(8'h0A, 32'd3060, 16'h0505);   // 0 and 2 released: mark cleared
    poll(8'h00, 32'd3070, 16'h0606);
    poll(8'h00, 32'd3090, 16'h0707);   // presses on 1 and 3
  endtask

  // Zero thresholds: one unchanged poll debounces, hold fires right after.
  task automatic test_zero_thresholds();
    set_thresholds(16'd0, 16'd0);
    poll(8'h80, 32'd5000, 16'h00C0);
    poll(8'h80, 32'd5000, 16'h00C1);
    poll(8'h80, 32'd5000, 16'h00C2);   // hold on button 7
    poll(8'h40, 32'd5001, 16'h00C3);
    poll(8'h40, 32'd5001, 16'h00C4);
    poll(8'h00, 32'd5002, 16'h00C5);
    poll(8'h00, 32'd5002, 16'h00C6);   // press on button 6
  endtask

  // Largest thresholds, with the time counter wrapping through zero.
  task automatic test_max_thresholds_wrap();
    set_thresholds(16'hFFFF, 16'hFFFF);
    poll(8'h10, 32'hFFFF_F000, 16'hBEEF);
    poll(8'h10, 32'hFFFF_F000 + 32'd65534, 16'hBEEF);
    poll(8'h10, 32'hFFFF_F000 + 32'd65535, 16'hCAFE);   // stable across the wrap
    poll(8'h10, 32'hFFFF_F000 + 32'd131070, 16'hF00D);  // hold
  endtask

  // ---------------------------------------------------------------------
  // Random gestures: intended button levels change now and then, raw
  // levels bounce a little, with some reset items and pure noise polls.
  // Time steps are scaled to the thresholds so presses complete.
  // ---------------------------------------------------------------------
  task automatic test_random_gestures(input logic [CFG_W-1:0] debounce,
                                      input logic [CFG_W-1:0] hold, input int count,
                                      input int unsigned max_step,
                                      input logic [TIME_W-1:0] start_ms);
    logic [RAW_W-1:0]  intended;
    logic [RAW_W-1:0]  raw_bits;
    logic [TIME_W-1:0] now;
    int unsigned       step_ms;
    int                sel;
    int                burst_left;
    set_thresholds(debounce, hold);
    intended   = '0;
    now        = start_ms;
    burst_left = $urandom_range(1, 24);
    for (int n = 0; n < count; n++) begin
      step_ms = $urandom_range(0, max_step);
      if ($urandom_range(0, 15) == 0) step_ms = $urandom_range(0, max_step * 8);
      now = now + step_ms;
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        raw_bits = intended ^ RAW_W'($urandom_range(0, 255) & $urandom_range(0, 255));
        send_item(KIND_RESET, raw_bits, now, EPOCH_W'($urandom_range(0, 65535)));
      end else if (sel < 9) begin
        poll(RAW_W'($urandom_range(0, 255)), now, EPOCH_W'($urandom_range(0, 65535)));
      end else begin
        if ($urandom_range(0, 2) == 0) intended[$urandom_range(0, RAW_W - 1)] ^= 1'b1;
        raw_bits = intended;
        if ($urandom_range(0, 9) == 0) raw_bits[$urandom_range(0, RAW_W - 1)] ^= 1'b1;
        poll(raw_bits, now, EPOCH_W'($urandom_range(0, 65535)));
      end
      random_items++;
      burst_left--;
      if (burst_left == 0) begin
        pause_input($urandom_range(1, 15));
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] rnd_debounce;
    logic [CFG_W-1:0] rnd_hold;
    error_count      = 0;
    items_sent       = 0;
    random_items     = 0;
    gestures_checked = 0;
    reg_writes       = 0;
    cycle_count      = 0;
    stall_left       = 0;
    stall_mode       = 0;
    clear_button_model();

    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_DEBOUNCE_MS;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_kind          <= KIND_POLL;
    in_buttons_down  <= '0;
    in_now_ms        <= '0;
    in_control_epoch <= '0;
    out_ready        <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_press_and_hold();
    test_reset_item();
    test_zero_thresholds();
    test_max_thresholds_wrap();

    rnd_debounce = CFG_W'($urandom_range(0, 30));
    rnd_hold     = CFG_W'($urandom_range(0, 200));
    test_random_gestures(16'd5, 16'd40, 100, 8, $urandom);
    test_random_gestures(16'd0, 16'd0, 60, 3, $urandom);
    test_random_gestures(16'd0, 16'd25, 60, 6, $urandom);
    test_random_gestures(16'hFFFF, 16'hFFFF, 60, 20000, 32'hFFF0_0000);
    test_random_gestures(rnd_debounce, rnd_hold, 60,
                         (int'(rnd_debounce) + int'(rnd_hold)) / 4 + 1, $urandom);
    test_random_gestures(DEBOUNCE_MS_RST, HOLD_MS_RST, 60, 60, $urandom);

    // drain, then leave room for a trailing item that gives no gesture
    in_valid <= 1'b0;
    wait_for_gestures();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (expected_gestures.size() != 0) begin
      gesture_t left_g;
      left_g = expected_gestures.pop_front();
      $display("%0t: missing gesture: expected button %0d kind %0d epoch %0h, actual none",
               $time, left_g.idx, left_g.gesture, left_g.epoch);
      error_count++;
    end

    $display("Run covered %0d items (%0d random) over %0d register writes,",
             items_sent, random_items, reg_writes);
    $display("with %0d gestures checked and %0d mismatches.", gestures_checked, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
